>>> hw/rtl/vp8_rtp_packetizer_assert.svh
// ----------------------------------------------------------------------------
// VP8 RTP packetizer assertion macros
// Shared property templates for the packetizer checks.
// ----------------------------------------------------------------------------
`ifndef VP8_RTP_PACKETIZER_ASSERT_SVH
`define VP8_RTP_PACKETIZER_ASSERT_SVH

// same-cycle implication, masked during reset
`define VP8PK_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("vp8 packetizer check failed");

// next-cycle implication, checked during reset too
`define VP8PK_ASSERT_NEXT(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("vp8 packetizer check failed");

`endif

>>> hw/rtl/vp8pk_pkg.sv
// ----------------------------------------------------------------------------
// VP8 RTP packetizer package
// Widths, register codes, descriptor constants and shared structs.
// ----------------------------------------------------------------------------
package vp8pk_pkg;

   // frame length field width
   localparam int FRAME_LENGTH_BITS = 20;
   localparam logic [FRAME_LENGTH_BITS-1:0] FRAME_ONE = FRAME_LENGTH_BITS'(1);

   // stream widths, whole bytes
   localparam int REQ_FIELD_BITS = 8 + FRAME_LENGTH_BITS + 32;
   localparam int REQ_TDATA_BITS = ((REQ_FIELD_BITS + 7) / 8) * 8;
   localparam int RSP_FIELD_BITS = 8 + 1 + 1 + 16 + 32 + 1;
   localparam int RSP_TDATA_BITS = ((RSP_FIELD_BITS + 7) / 8) * 8;
   localparam int RSP_TUSER_BITS = 2;

   // register port
   localparam int CSR_ADDR_BITS = 5;
   localparam int CSR_DATA_BITS = 32;

   typedef enum logic [2:0] {
      CSR_MTU       = 3'd0,
      CSR_PID_EN    = 3'd1,
      CSR_SSRC      = 3'd2,
      CSR_KIND      = 3'd3,
      CSR_FIRST_SEQ = 3'd4,
      CSR_START_PID = 3'd5
   } csr_index_type;

   localparam logic [15:0] MTU_RESET  = 16'd1200;
   localparam logic [6:0]  KIND_RESET = 7'd96;

   // descriptor sizes
   localparam logic [2:0] DSIZE_BASIC = 3'd1;
   localparam logic [2:0] DSIZE_SHORT = 3'd3;
   localparam logic [2:0] DSIZE_LONG  = 3'd4;

   // descriptor bits
   localparam logic [7:0]  DESC_S_BIT     = 8'h10;
   localparam logic [7:0]  DESC_X_BIT     = 8'h80;
   localparam logic [7:0]  DESC_I_BIT     = 8'h80;
   localparam logic [7:0]  DESC_M_BIT     = 8'h80;
   localparam logic [14:0] PID_SHORT_LIMIT = 15'd128;

   // configuration seen by the frame tracker
   typedef struct packed {
      logic [15:0] mtu;
      logic        pid_en;
      logic        seq_load;
      logic [15:0] seq_value;
      logic        pid_load;
      logic [14:0] pid_value;
   } cfg_type;

   // everything one accepted byte will emit
   typedef struct packed {
      logic            reject;
      logic [2:0]      last_idx;
      logic [3:0][7:0] desc;
      logic [7:0]      data;
      logic            pe;
      logic            mk;
      logic [15:0]     seq;
      logic [31:0]     ts;
   } plan_type;

   // one result transaction
   typedef struct packed {
      logic [7:0]  out_byte;
      logic        is_descriptor;
      logic        packet_start;
      logic        packet_end;
      logic        marker;
      logic [15:0] packet_seq;
      logic [31:0] packet_timestamp;
      logic        frame_rejected;
      logic        last_of_input;
   } result_type;

endpackage

>>> hw/rtl/vp8pk_csr.sv
// ----------------------------------------------------------------------------
// VP8 RTP packetizer register file
// APB-style register bank with counter load strobes.
// ----------------------------------------------------------------------------
module vp8pk_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [vp8pk_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [vp8pk_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [vp8pk_pkg::CSR_DATA_BITS-1:0] csr_prdata,
   output logic                                csr_pready,
   output vp8pk_pkg::cfg_type                  cfg
);

   logic [15:0] mtu_ff,       mtu_in;
   logic        pid_en_ff,    pid_en_in;
   logic [31:0] ssrc_ff,      ssrc_in;
   logic [6:0]  kind_ff,      kind_in;
   logic [15:0] first_seq_ff, first_seq_in;
   logic [14:0] start_pid_ff, start_pid_in;

   vp8pk_pkg::csr_index_type idx;
   logic                     wr_en;
   logic                     seq_load;
   logic                     pid_load;

   assign csr_pready = 1'b1;
   assign idx        = vp8pk_pkg::csr_index_type'(csr_paddr[4:2]);
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;

   // write decode
   always_comb begin
      mtu_in       = mtu_ff;
      pid_en_in    = pid_en_ff;
      ssrc_in      = ssrc_ff;
      kind_in      = kind_ff;
      first_seq_in = first_seq_ff;
      start_pid_in = start_pid_ff;
      seq_load     = 1'b0;
      pid_load     = 1'b0;
      if (wr_en) begin
         case (idx)
            vp8pk_pkg::CSR_MTU:       mtu_in    = csr_pwdata[15:0];
            vp8pk_pkg::CSR_PID_EN:    pid_en_in = csr_pwdata[0];
            vp8pk_pkg::CSR_SSRC:      ssrc_in   = csr_pwdata[31:0];
            vp8pk_pkg::CSR_KIND:      kind_in   = csr_pwdata[6:0];
            vp8pk_pkg::CSR_FIRST_SEQ: begin
               first_seq_in = csr_pwdata[15:0];
               seq_load     = 1'b1;
            end
            vp8pk_pkg::CSR_START_PID: begin
               start_pid_in = csr_pwdata[14:0];
               pid_load     = 1'b1;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mtu_ff       <= vp8pk_pkg::MTU_RESET;
         pid_en_ff    <= 1'b0;
         ssrc_ff      <= '0;
         kind_ff      <= vp8pk_pkg::KIND_RESET;
         first_seq_ff <= '0;
         start_pid_ff <= '0;
      end else begin
         mtu_ff       <= mtu_in;
         pid_en_ff    <= pid_en_in;
         ssrc_ff      <= ssrc_in;
         kind_ff      <= kind_in;
         first_seq_ff <= first_seq_in;
         start_pid_ff <= start_pid_in;
      end
   end

   // read mux
   always_comb begin
      case (idx)
         vp8pk_pkg::CSR_MTU:       csr_prdata = 32'(mtu_ff);
         vp8pk_pkg::CSR_PID_EN:    csr_prdata = 32'(pid_en_ff);
         vp8pk_pkg::CSR_SSRC:      csr_prdata = ssrc_ff;
         vp8pk_pkg::CSR_KIND:      csr_prdata = 32'(kind_ff);
         vp8pk_pkg::CSR_FIRST_SEQ: csr_prdata = 32'(first_seq_ff);
         vp8pk_pkg::CSR_START_PID: csr_prdata = 32'(start_pid_ff);
         default:                  csr_prdata = '0;
      endcase
   end

   // write data goes straight to the counters on a load
   assign cfg = '{mtu:       mtu_ff,
                  pid_en:    pid_en_ff,
                  seq_load:  seq_load,
                  seq_value: csr_pwdata[15:0],
                  pid_load:  pid_load,
                  pid_value: csr_pwdata[14:0]};

endmodule

>>> hw/rtl/vp8pk_frame.sv
// ----------------------------------------------------------------------------
// VP8 RTP packetizer frame tracker
// Holds frame and fragment state; turns each accepted byte into a plan.
// ----------------------------------------------------------------------------
module vp8pk_frame (
   input  logic                                    clock,
   input  logic                                    reset,
   input  vp8pk_pkg::cfg_type                      cfg,
   input  logic                                    accept,
   input  logic [7:0]                              data_byte,
   input  logic [vp8pk_pkg::FRAME_LENGTH_BITS-1:0] frame_bytes,
   input  logic [31:0]                             frame_timestamp,
   output logic                                    plan_valid,
   output vp8pk_pkg::plan_type                     plan
);

   localparam int FLB = vp8pk_pkg::FRAME_LENGTH_BITS;

   logic [FLB-1:0] pos_ff,   pos_in;
   logic [FLB-1:0] start_ff, start_in;
   logic [15:0]    fill_ff,  fill_in;
   logic [2:0]     dsize_ff, dsize_in;
   logic [15:0]    seq_ff,   seq_in;
   logic [14:0]    pid_ff,   pid_in;
   logic           drop_ff,  drop_in;
   logic           first_ff, first_in;

   logic [FLB-1:0] len;
   logic [FLB-1:0] remain;
   logic           last_byte;
   logic           frame_head;
   logic [2:0]     pid_size;
   logic [2:0]     dsize;
   logic           room;
   logic           reject;
   logic [15:0]    max_frag;
   logic           has_desc;
   logic           pe;
   logic           mk;

   // per-byte decisions
   always_comb begin
      len        = (frame_bytes == '0) ? vp8pk_pkg::FRAME_ONE : frame_bytes;
      last_byte  = pos_ff >= (len - vp8pk_pkg::FRAME_ONE);
      frame_head = pos_ff == '0;
      if (!cfg.pid_en || pid_ff == '0)
         pid_size = vp8pk_pkg::DSIZE_BASIC;
      else if (pid_ff < vp8pk_pkg::PID_SHORT_LIMIT)
         pid_size = vp8pk_pkg::DSIZE_SHORT;
      else
         pid_size = vp8pk_pkg::DSIZE_LONG;
      dsize    = frame_head ? pid_size : dsize_ff;
      room     = cfg.mtu > 16'(dsize);
      reject   = frame_head & ~room;
      max_frag = room ? (cfg.mtu - 16'(dsize)) : 16'd1;
      remain   = len - start_ff;
      mk       = (len <= start_ff) | (32'(remain) <= 32'(max_frag));
      has_desc = fill_ff == '0;
      pe       = last_byte | ((17'(fill_ff) + 17'd1) >= 17'(max_frag));
   end

   // plan for the emitter
   always_comb begin
      plan.reject   = reject;
      plan.last_idx = (!reject && has_desc) ? dsize : 3'd0;
      plan.desc[0]  = (first_ff ? vp8pk_pkg::DESC_S_BIT : 8'h00)
                    | ((dsize > vp8pk_pkg::DSIZE_BASIC) ? vp8pk_pkg::DESC_X_BIT : 8'h00);
      plan.desc[1]  = vp8pk_pkg::DESC_I_BIT;
      plan.desc[2]  = (dsize == vp8pk_pkg::DSIZE_SHORT) ? {1'b0, pid_ff[6:0]}
                    : (vp8pk_pkg::DESC_M_BIT | {1'b0, pid_ff[14:8]});
      plan.desc[3]  = pid_ff[7:0];
      plan.data     = data_byte;
      plan.pe       = pe;
      plan.mk       = mk;
      plan.seq      = seq_ff;
      plan.ts       = frame_timestamp;
      plan_valid    = accept & (reject | ~drop_ff);
   end

   // state update on each accepted byte
   always_comb begin
      pos_in   = pos_ff;
      start_in = start_ff;
      fill_in  = fill_ff;
      dsize_in = dsize_ff;
      seq_in   = seq_ff;
      pid_in   = pid_ff;
      drop_in  = drop_ff;
      first_in = first_ff;
      if (accept) begin
         if (reject) begin
            dsize_in = dsize;
            if (last_byte) begin
               pos_in   = '0;
               start_in = '0;
               fill_in  = '0;
               first_in = 1'b1;
               drop_in  = 1'b0;
            end else begin
               drop_in = 1'b1;
               pos_in  = vp8pk_pkg::FRAME_ONE;
            end
         end else if (drop_ff) begin
            if (last_byte) begin
               pos_in   = '0;
               start_in = '0;
               fill_in  = '0;
               first_in = 1'b1;
               drop_in  = 1'b0;
            end else begin
               pos_in = pos_ff + vp8pk_pkg::FRAME_ONE;
            end
         end else begin
            dsize_in = dsize;
            if (has_desc)
               first_in = 1'b0;
            if (pe) begin
               seq_in   = seq_ff + 16'd1;
               fill_in  = '0;
               start_in = pos_ff + vp8pk_pkg::FRAME_ONE;
            end else begin
               fill_in = fill_ff + 16'd1;
            end
            if (last_byte) begin
               pos_in   = '0;
               start_in = '0;
               fill_in  = '0;
               first_in = 1'b1;
               drop_in  = 1'b0;
               if (cfg.pid_en)
                  pid_in = pid_ff + 15'd1;
            end else begin
               pos_in = pos_ff + vp8pk_pkg::FRAME_ONE;
            end
         end
      end
      // counter loads from the register port
      if (cfg.seq_load)
         seq_in = cfg.seq_value;
      if (cfg.pid_load)
         pid_in = cfg.pid_value;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         start_ff <= '0;
         fill_ff  <= '0;
         dsize_ff <= vp8pk_pkg::DSIZE_BASIC;
         seq_ff   <= '0;
         pid_ff   <= '0;
         drop_ff  <= 1'b0;
         first_ff <= 1'b1;
      end else begin
         pos_ff   <= pos_in;
         start_ff <= start_in;
         fill_ff  <= fill_in;
         dsize_ff <= dsize_in;
         seq_ff   <= seq_in;
         pid_ff   <= pid_in;
         drop_ff  <= drop_in;
         first_ff <= first_in;
      end
   end

endmodule

>>> hw/rtl/vp8pk_emit.sv
// ----------------------------------------------------------------------------
// VP8 RTP packetizer emitter
// Holds one plan and walks its results into the output register.
// ----------------------------------------------------------------------------
module vp8pk_emit (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    plan_valid,
   input  vp8pk_pkg::plan_type     plan,
   output logic                    plan_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output vp8pk_pkg::result_type   rsp
);

   vp8pk_pkg::plan_type   plan_ff,  plan_in;
   logic                  pvld_ff,  pvld_in;
   logic [2:0]            idx_ff,   idx_in;
   vp8pk_pkg::result_type rsp_ff,   rsp_in;
   logic                  rvld_ff,  rvld_in;

   logic out_free;
   logic step;
   logic done;
   logic is_data;

   assign out_free   = ~rvld_ff | rsp_ready;
   assign step       = pvld_ff & out_free;
   assign done       = step & (idx_ff == plan_ff.last_idx);
   assign plan_ready = ~pvld_ff | done;
   assign is_data    = idx_ff == plan_ff.last_idx;

   // result for the current index
   always_comb begin
      rsp_in.packet_seq       = plan_ff.seq;
      rsp_in.packet_timestamp = plan_ff.ts;
      if (plan_ff.reject) begin
         rsp_in.out_byte       = '0;
         rsp_in.is_descriptor  = 1'b0;
         rsp_in.packet_start   = 1'b0;
         rsp_in.packet_end     = 1'b0;
         rsp_in.marker         = 1'b0;
         rsp_in.frame_rejected = 1'b1;
         rsp_in.last_of_input  = 1'b1;
      end else begin
         rsp_in.out_byte       = is_data ? plan_ff.data : plan_ff.desc[idx_ff[1:0]];
         rsp_in.is_descriptor  = ~is_data;
         rsp_in.packet_start   = ~is_data & (idx_ff == 3'd0);
         rsp_in.packet_end     = is_data & plan_ff.pe;
         rsp_in.marker         = plan_ff.mk;
         rsp_in.frame_rejected = 1'b0;
         rsp_in.last_of_input  = is_data;
      end
   end

   // plan holding register and index
   always_comb begin
      plan_in = plan_ff;
      pvld_in = pvld_ff;
      idx_in  = idx_ff;
      if (plan_valid && plan_ready) begin
         plan_in = plan;
         pvld_in = 1'b1;
         idx_in  = 3'd0;
      end else if (done) begin
         pvld_in = 1'b0;
      end else if (step) begin
         idx_in = idx_ff + 3'd1;
      end
   end

   assign rvld_in = step | (rvld_ff & ~rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         pvld_ff <= 1'b0;
         idx_ff  <= '0;
         rvld_ff <= 1'b0;
      end else begin
         pvld_ff <= pvld_in;
         idx_ff  <= idx_in;
         rvld_ff <= rvld_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      plan_ff <= plan_in;
      if (step)
         rsp_ff <= rsp_in;
   end

   assign rsp_valid = rvld_ff;
   assign rsp       = rsp_ff;

endmodule

>>> hw/rtl/vp8_rtp_packetizer.sv
// ----------------------------------------------------------------------------
// VP8 RTP payload packetizer
// Cuts VP8 frame bytes into fragments, each led by a payload descriptor.
//
//  channel  | dir | transaction
//  req_     | in  | one frame byte with frame length and timestamp
//  rsp_     | out | one descriptor or payload byte with packet tags
//  csr_     | in  | APB-style register read or write
//
// A byte inside a fragment gives one result; a byte that opens a fragment
// also gives its descriptor of 1, 3 or 4 bytes first. A dropped byte gives no
// result. The single output register passes one result a cycle while
// rsp_tready is high. Reset is synchronous and loads register defaults.
// rsp_tready low holds the output; req_tready drops while a byte's results
// are still draining.
// ----------------------------------------------------------------------------
module vp8_rtp_packetizer (
   input  logic                                 clock,
   input  logic                                 reset,
   // data_byte[7:0], frame_bytes, frame_timestamp, zero pad
   input  logic [vp8pk_pkg::REQ_TDATA_BITS-1:0] req_tdata,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // out_byte[7:0], packet_start, marker, packet_seq[15:0],
   // packet_timestamp[31:0], last_of_input, zero pad
   output logic [vp8pk_pkg::RSP_TDATA_BITS-1:0] rsp_tdata,
   // is_descriptor, frame_rejected
   output logic [vp8pk_pkg::RSP_TUSER_BITS-1:0] rsp_tuser,
   output logic                                 rsp_tlast,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [vp8pk_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  logic [vp8pk_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic [vp8pk_pkg::CSR_DATA_BITS-1:0]  csr_prdata,
   output logic                                 csr_pready
);

   `include "vp8_rtp_packetizer_assert.svh"

   localparam int FLB = vp8pk_pkg::FRAME_LENGTH_BITS;

   vp8pk_pkg::cfg_type    cfg;
   vp8pk_pkg::plan_type   plan;
   vp8pk_pkg::result_type rsp;
   logic                  plan_valid;
   logic                  accept;

   assign accept = req_tvalid & req_tready;

   vp8pk_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   vp8pk_frame u_frame (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .accept          (accept),
      .data_byte       (req_tdata[7:0]),
      .frame_bytes     (req_tdata[8 +: FLB]),
      .frame_timestamp (req_tdata[8 + FLB +: 32]),
      .plan_valid      (plan_valid),
      .plan            (plan)
   );

   vp8pk_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .plan_valid (plan_valid),
      .plan       (plan),
      .plan_ready (req_tready),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp        (rsp)
   );

   // pack the result transaction
   assign rsp_tdata = vp8pk_pkg::RSP_TDATA_BITS'({rsp.last_of_input,
                                                  rsp.packet_timestamp,
                                                  rsp.packet_seq,
                                                  rsp.marker,
                                                  rsp.packet_start,
                                                  rsp.out_byte});
   assign rsp_tuser = {rsp.frame_rejected, rsp.is_descriptor};
   assign rsp_tlast = rsp.packet_end;

   // checks
   `VP8PK_ASSERT_SAME(a_reject_single, clock, reset, rsp_tvalid && rsp_tuser[1], rsp_tdata[58] && !rsp_tlast && !rsp_tuser[0])
   `VP8PK_ASSERT_SAME(a_desc_not_end, clock, reset, rsp_tvalid && rsp_tuser[0], !rsp_tlast && !rsp_tdata[58])
   `VP8PK_ASSERT_SAME(a_end_is_last, clock, reset, rsp_tvalid && rsp_tlast, rsp_tdata[58])
   `VP8PK_ASSERT_NEXT(a_reset_idle, clock, reset, !rsp_tvalid && req_tready)

endmodule

>>> sim/vp8_rtp_packetizer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// VP8 RTP packetizer testbench
// Streams frame bytes into the packetizer and checks every descriptor and
// payload byte against a cycle-free model of the fragmenting. A short table of
// hand-picked bytes and register writes comes first. Random frames follow,
// with random gaps and stalls on both streams.
// ----------------------------------------------------------------------------
module vp8_rtp_packetizer_tb;

   localparam int RANDOM_ITEMS = 450;
   localparam int QUIET_ITEMS  = 60;
   localparam int SETTLE_CYCLES = 8;

   typedef enum logic [1:0] {ROW_BYTE, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type             kind;
      vp8pk_pkg::csr_index_type idx;
      logic [31:0]              value;
      logic [7:0]               data;
      logic [19:0]              len;
      logic [31:0]              ts;
      logic                     typed;
      vp8pk_pkg::result_type    want;
   } stim_row_type;

   typedef struct packed {
      logic                  typed;
      vp8pk_pkg::result_type want;
   } typed_note_type;

   logic                                 clock;
   logic                                 reset;
   logic [vp8pk_pkg::REQ_TDATA_BITS-1:0] req_tdata;
   logic                                 req_tvalid;
   logic                                 req_tready;
   logic [vp8pk_pkg::RSP_TDATA_BITS-1:0] rsp_tdata;
   logic [vp8pk_pkg::RSP_TUSER_BITS-1:0] rsp_tuser;
   logic                                 rsp_tlast;
   logic                                 rsp_tvalid;
   logic                                 rsp_tready = 1'b1;
   logic                                 csr_psel;
   logic                                 csr_penable;
   logic                                 csr_pwrite;
   logic [vp8pk_pkg::CSR_ADDR_BITS-1:0]  csr_paddr;
   logic [vp8pk_pkg::CSR_DATA_BITS-1:0]  csr_pwdata;
   logic [vp8pk_pkg::CSR_DATA_BITS-1:0]  csr_prdata;
   logic                                 csr_pready;

   // model of the packetizer: registers and frame tracking
   logic [15:0] mtu;
   logic        pid_en;
   logic [19:0] byte_pos;
   logic [15:0] frag_fill;
   logic [2:0]  dsize;
   logic [15:0] seq_ctr;
   logic [14:0] pic_ctr;
   logic        dropping;
   logic        first_frag;

   vp8pk_pkg::result_type pending_bytes [$];
   typed_note_type        typed_notes [$];
   stim_row_type          directed_rows [$];
   int                    mismatch_count;
   bit                    quiet = 1'b0;
   int                    stall_left = 0;

   vp8_rtp_packetizer dut (
      .clock       (clock),
      .reset       (reset),
      .req_tdata   (req_tdata),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("vp8_rtp_packetizer_tb: FAIL");
      $finish;
   end

   // ---------------------------------------------------------------- model

   function automatic void queue_result(input logic [7:0] b, input logic desc,
                                        input logic ps, input logic pe,
                                        input logic mk, input logic [31:0] ts,
                                        input logic rej, input logic last);
      vp8pk_pkg::result_type r;
      r.out_byte         = b;
      r.is_descriptor    = desc;
      r.packet_start     = ps;
      r.packet_end       = pe;
      r.marker           = mk;
      r.packet_seq       = seq_ctr;
      r.packet_timestamp = ts;
      r.frame_rejected   = rej;
      r.last_of_input    = last;
      pending_bytes = {pending_bytes, r};
   endfunction

   function automatic void close_frame();
      byte_pos   = '0;
      frag_fill  = '0;
      first_frag = 1'b1;
      dropping   = 1'b0;
   endfunction

   // expected results of one accepted frame byte
   function automatic void packetize_byte(input logic [7:0] data,
                                          input logic [19:0] len_in,
                                          input logic [31:0] ts);
      logic [19:0] len;
      logic        last_byte;
      int          max_frag;
      logic [19:0] frag_start;
      logic [19:0] remain;
      logic        mk;
      logic        pe;
      logic [7:0]  desc [4];
      len = (len_in == '0) ? 20'd1 : len_in;
      last_byte = (byte_pos >= len - 20'd1);

      // descriptor size is latched at the first byte; no room drops the frame
      if (byte_pos == '0) begin
         if (!pid_en || pic_ctr == '0) dsize = vp8pk_pkg::DSIZE_BASIC;
         else if (pic_ctr < vp8pk_pkg::PID_SHORT_LIMIT) dsize = vp8pk_pkg::DSIZE_SHORT;
         else dsize = vp8pk_pkg::DSIZE_LONG;
         if (int'(mtu) <= int'(dsize)) begin
            queue_result(8'h00, 1'b0, 1'b0, 1'b0, 1'b0, ts, 1'b1, 1'b1);
            if (last_byte) begin
               close_frame();
            end else begin
               dropping = 1'b1;
               byte_pos = 20'd1;
            end
            return;
         end
      end

      if (dropping) begin
         if (last_byte) close_frame();
         else byte_pos = byte_pos + 20'd1;
         return;
      end

      max_frag = int'(mtu) - int'(dsize);
      if (max_frag < 1) max_frag = 1;
      frag_start = (byte_pos >= 20'(frag_fill)) ? byte_pos - 20'(frag_fill) : '0;
      remain = (len > frag_start) ? len - frag_start : '0;
      mk = (int'(remain) <= max_frag);

      // descriptor leads every fragment
      if (frag_fill == '0) begin
         desc[0] = (first_frag ? vp8pk_pkg::DESC_S_BIT : 8'h00)
                 | (dsize > vp8pk_pkg::DSIZE_BASIC ? vp8pk_pkg::DESC_X_BIT : 8'h00);
         desc[1] = vp8pk_pkg::DESC_I_BIT;
         desc[2] = (dsize == vp8pk_pkg::DSIZE_SHORT) ? {1'b0, pic_ctr[6:0]}
                 : (vp8pk_pkg::DESC_M_BIT | {1'b0, pic_ctr[14:8]});
         desc[3] = pic_ctr[7:0];
         for (int k = 0; k < int'(dsize); k++)
            queue_result(desc[k], 1'b1, k == 0, 1'b0, mk, ts, 1'b0, 1'b0);
         first_frag = 1'b0;
      end

      pe = last_byte || (int'(frag_fill) + 1 >= max_frag);
      queue_result(data, 1'b0, 1'b0, pe, mk, ts, 1'b0, 1'b1);

      if (pe) begin
         seq_ctr   = seq_ctr + 16'd1;
         frag_fill = '0;
      end else begin
         frag_fill = frag_fill + 16'd1;
      end

      if (last_byte) begin
         close_frame();
         if (pid_en) pic_ctr = pic_ctr + 15'd1;
      end else begin
         byte_pos = byte_pos + 20'd1;
      end
   endfunction

   // ---------------------------------------------------------------- checking

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] seen);
      if (want !== seen) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, seen);
         mismatch_count++;
      end
   endfunction

   // predict on accepted bytes, then compare accepted results
   always @(posedge clock) begin : watch
      int                    base;
      typed_note_type        note;
      vp8pk_pkg::result_type want;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            base = pending_bytes.size();
            packetize_byte(req_tdata[7:0], req_tdata[27:8], req_tdata[59:28]);
            note = typed_notes.pop_front();
            if (note.typed && pending_bytes.size() > base) pending_bytes[base] = note.want;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (pending_bytes.size() == 0) begin
               $error("unexpected result transaction: tdata 0x%0h tuser 0x%0h",
                      rsp_tdata, rsp_tuser);
               mismatch_count++;
            end else begin
               want = pending_bytes.pop_front();
               check_field("out_byte", want.out_byte, rsp_tdata[7:0]);
               check_field("is_descriptor", want.is_descriptor, rsp_tuser[0]);
               check_field("packet_start", want.packet_start, rsp_tdata[8]);
               check_field("packet_end", want.packet_end, rsp_tlast);
               check_field("marker", want.marker, rsp_tdata[9]);
               check_field("packet_seq", want.packet_seq, rsp_tdata[25:10]);
               check_field("packet_timestamp", want.packet_timestamp, rsp_tdata[57:26]);
               check_field("frame_rejected", want.frame_rejected, rsp_tuser[1]);
               check_field("last_of_input", want.last_of_input, rsp_tdata[58]);
            end
         end
      end
   end

   // result side backpressure in random bursts
   always @(negedge clock) begin
      if (stall_left > 0 && !quiet) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 11) == 0) begin
         stall_left <= $urandom_range(0, 15);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // ---------------------------------------------------------------- drivers

   // called and returns at a falling edge
   task automatic send_byte(input logic [7:0] data, input logic [19:0] len,
                            input logic [31:0] ts, input logic typed,
                            input vp8pk_pkg::result_type want);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(negedge clock);
      end
      typed_notes = {typed_notes, typed_note_type'{typed, want}};
      req_tvalid <= 1'b1;
      req_tdata  <= {{(vp8pk_pkg::REQ_TDATA_BITS - vp8pk_pkg::REQ_FIELD_BITS){1'b0}},
                     ts, len, data};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // drain all results, then let a dropped byte finish
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (pending_bytes.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic csr_write(input vp8pk_pkg::csr_index_type idx, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         vp8pk_pkg::CSR_MTU:       mtu     = value[15:0];
         vp8pk_pkg::CSR_PID_EN:    pid_en  = value[0];
         vp8pk_pkg::CSR_FIRST_SEQ: seq_ctr = value[15:0];
         vp8pk_pkg::CSR_START_PID: pic_ctr = value[14:0];
         default: ;
      endcase
      @(negedge clock);
   endtask

   function automatic stim_row_type byte_row(input logic [7:0] data, input logic [19:0] len,
                                             input logic [31:0] ts);
      stim_row_type r;
      r = '0;
      r.kind = ROW_BYTE;
      r.data = data;
      r.len  = len;
      r.ts   = ts;
      return r;
   endfunction

   function automatic stim_row_type checked_row(input logic [7:0] data,
                                                input logic [19:0] len,
                                                input logic [31:0] ts,
                                                input vp8pk_pkg::result_type want);
      stim_row_type r;
      r = byte_row(data, len, ts);
      r.typed = 1'b1;
      r.want  = want;
      return r;
   endfunction

   function automatic stim_row_type csr_row(input vp8pk_pkg::csr_index_type idx,
                                            input logic [31:0] value);
      stim_row_type r;
      r = '0;
      r.kind  = ROW_CSR;
      r.idx   = idx;
      r.value = value;
      return r;
   endfunction

   // small sizes mostly, so that frames split into many fragments
   function automatic logic [15:0] pick_mtu();
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 5))
               0: return 16'd0;
               1: return 16'd1;
               2: return 16'd3;
               3: return 16'd4;
               4: return 16'd5;
               default: return 16'hFFFF;
            endcase
         end
         1: return 16'($urandom_range(0, 16'hFFFF));
         default: return 16'($urandom_range(2, 24));
      endcase
   endfunction

   function automatic logic [31:0] pick_picture_id();
      case ($urandom_range(0, 4))
         0: return 32'd0;
         1: return $urandom_range(120, 135);
         2: return 32'h7FFF - $urandom_range(0, 2);
         3: return $urandom_range(0, 15'h7FFF);
         default: return $urandom_range(1, 5);
      endcase
   endfunction

   // ---------------------------------------------------------------- stimulus

   initial begin
      int          sent;
      int          frames;
      logic [19:0] len;
      logic [19:0] item_len;
      logic [31:0] ts;

      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      mismatch_count = 0;

      // register defaults and frame tracker after reset
      mtu      = vp8pk_pkg::MTU_RESET;
      pid_en   = 1'b0;
      seq_ctr  = '0;
      pic_ctr  = '0;
      dsize    = vp8pk_pkg::DSIZE_BASIC;
      close_frame();

      directed_rows = {
         // defaults: one byte descriptor with S set, whole frame in one packet
         checked_row(8'hA5, 20'd3, 32'h0000_0000,
                     vp8pk_pkg::result_type'{8'h10, 1'b1, 1'b1, 1'b0, 1'b1, 16'h0000,
                                             32'h0, 1'b0, 1'b0}),
         byte_row(8'h00, 20'd3, 32'h0000_0000),
         byte_row(8'hFF, 20'd3, 32'h0000_0000),
         // zero frame length counts as one byte
         checked_row(8'h5A, 20'd0, 32'hFFFF_FFFF,
                     vp8pk_pkg::result_type'{8'h10, 1'b1, 1'b1, 1'b0, 1'b1, 16'h0001,
                                             32'hFFFF_FFFF, 1'b0, 1'b0}),
         csr_row(vp8pk_pkg::CSR_SSRC, 32'hFFFF_FFFF),
         csr_row(vp8pk_pkg::CSR_KIND, 32'h0000_007F),
         csr_row(vp8pk_pkg::CSR_FIRST_SEQ, 32'h0000_FFFF),
         csr_row(vp8pk_pkg::CSR_MTU, 32'd3),
         csr_row(vp8pk_pkg::CSR_PID_EN, 32'd1),
         csr_row(vp8pk_pkg::CSR_START_PID, 32'd5),
         // three byte descriptor fills the mtu: flagged once, rest dropped
         checked_row(8'h3C, 20'd2, 32'h1234_5678,
                     vp8pk_pkg::result_type'{8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 16'hFFFF,
                                             32'h1234_5678, 1'b1, 1'b1}),
         byte_row(8'hC3, 20'd2, 32'h1234_5678),
         // one data byte per fragment, sequence wraps
         csr_row(vp8pk_pkg::CSR_MTU, 32'd4),
         byte_row(8'h01, 20'd3, 32'h0000_0100),
         byte_row(8'h02, 20'd3, 32'h0000_0100),
         byte_row(8'h03, 20'd3, 32'h0000_0100),
         // 15-bit picture ID, then the wrap to ID zero
         csr_row(vp8pk_pkg::CSR_START_PID, 32'h0000_7FFF),
         csr_row(vp8pk_pkg::CSR_MTU, 32'd6),
         byte_row(8'h21, 20'd4, 32'h0000_0200),
         byte_row(8'h22, 20'd4, 32'h0000_0200),
         byte_row(8'h23, 20'd4, 32'h0000_0200),
         byte_row(8'h24, 20'd4, 32'h0000_0200),
         byte_row(8'h31, 20'd2, 32'h0000_0300),
         byte_row(8'h32, 20'd2, 32'h0000_0300),
         // mtu, picture ID and enable changed mid-frame, then length changes
         byte_row(8'h10, 20'd5, 32'h0000_0400),
         csr_row(vp8pk_pkg::CSR_MTU, 32'd2),
         csr_row(vp8pk_pkg::CSR_START_PID, 32'd200),
         csr_row(vp8pk_pkg::CSR_PID_EN, 32'd0),
         byte_row(8'h11, 20'd5, 32'h0000_0400),
         byte_row(8'h12, 20'h80000, 32'h0000_0400),
         byte_row(8'h13, 20'd2, 32'h0000_0400),
         // largest mtu and frame length, cut short by a length change
         csr_row(vp8pk_pkg::CSR_MTU, 32'h0000_FFFF),
         csr_row(vp8pk_pkg::CSR_PID_EN, 32'd1),
         byte_row(8'h80, 20'hFFFFF, 32'h8000_0000),
         byte_row(8'h7F, 20'd1, 32'h8000_0000),
         // zero mtu leaves no room even for the one byte descriptor
         csr_row(vp8pk_pkg::CSR_FIRST_SEQ, 32'h0000_8000),
         csr_row(vp8pk_pkg::CSR_PID_EN, 32'd0),
         csr_row(vp8pk_pkg::CSR_MTU, 32'd0),
         csr_row(vp8pk_pkg::CSR_SSRC, 32'd0),
         csr_row(vp8pk_pkg::CSR_KIND, 32'd0),
         checked_row(8'hEE, 20'd1, 32'h0000_0001,
                     vp8pk_pkg::result_type'{8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 16'h8000,
                                             32'h0000_0001, 1'b1, 1'b1})
      };

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_CSR) begin
            wait_idle();
            csr_write(directed_rows[i].idx, directed_rows[i].value);
         end else begin
            send_byte(directed_rows[i].data, directed_rows[i].len, directed_rows[i].ts,
                      directed_rows[i].typed, directed_rows[i].want);
         end
      end

      // random phases: new settings, then a few frames with some noise
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         if (!quiet) begin
            wait_idle();
            csr_write(vp8pk_pkg::CSR_MTU, 32'(pick_mtu()));
            csr_write(vp8pk_pkg::CSR_PID_EN, ($urandom_range(0, 2) != 0) ? 32'd1 : 32'd0);
            if ($urandom_range(0, 1) == 0)
               csr_write(vp8pk_pkg::CSR_START_PID, pick_picture_id());
            if ($urandom_range(0, 2) == 0) begin
               if ($urandom_range(0, 1) == 0)
                  csr_write(vp8pk_pkg::CSR_FIRST_SEQ, $urandom_range(16'hFFF0, 16'hFFFF));
               else
                  csr_write(vp8pk_pkg::CSR_FIRST_SEQ, $urandom_range(0, 16'hFFFF));
            end
            if ($urandom_range(0, 3) == 0) begin
               csr_write(vp8pk_pkg::CSR_SSRC, $urandom);
               csr_write(vp8pk_pkg::CSR_KIND, $urandom_range(0, 127));
            end
         end
         frames = $urandom_range(2, 6);
         for (int f = 0; f < frames && sent < RANDOM_ITEMS; f++) begin
            len = ($urandom_range(0, 9) == 0) ? 20'($urandom_range(25, 90))
                                              : 20'($urandom_range(1, 24));
            ts = $urandom;
            for (int i = 0; i < int'(len) && sent < RANDOM_ITEMS; i++) begin
               // settings changed while a frame is open
               if (!quiet && i > 0 && $urandom_range(0, 40) == 0) begin
                  wait_idle();
                  case ($urandom_range(0, 2))
                     0: csr_write(vp8pk_pkg::CSR_MTU, 32'(pick_mtu()));
                     1: csr_write(vp8pk_pkg::CSR_PID_EN, $urandom_range(0, 1));
                     default: csr_write(vp8pk_pkg::CSR_START_PID, pick_picture_id());
                  endcase
               end
               item_len = ($urandom_range(0, 24) == 0) ? 20'($urandom_range(0, 20'hFFFFF))
                                                       : len;
               if (sent >= RANDOM_ITEMS - QUIET_ITEMS) quiet = 1'b1;
               send_byte(8'($urandom_range(0, 255)), item_len, ts, 1'b0, '0);
               sent++;
            end
         end
      end

      wait_idle();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && pending_bytes.size() == 0) begin
         $display("vp8_rtp_packetizer_tb: PASS");
      end else begin
         $display("vp8_rtp_packetizer_tb: FAIL");
      end
      $finish;
   end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/vp8pk_pkg.sv
hw/rtl/vp8pk_csr.sv
hw/rtl/vp8pk_frame.sv
hw/rtl/vp8pk_emit.sv
hw/rtl/vp8_rtp_packetizer.sv
sim/vp8_rtp_packetizer_tb.sv
